### rtl/qjs_pkg.sv
// qjs_pkg: shared constants, payload types, sequencer steps and helpers
// for the two-level quantum jump step unit
// no dependencies
package qjs_pkg;

    // newton refinement count for the reciprocal square root
    localparam int NORM_ITERATIONS = 4;
    localparam int IterW = (NORM_ITERATIONS > 1) ? $clog2(NORM_ITERATIONS) : 1;

    // amplitude register file: a_re, a_im, b_re, b_im
    localparam int NumAmps = 4;
    localparam int AmpIdxW = 2;

    // configuration port
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 32;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RABI   = 2'd0,
        CFG_DETUNE = 2'd1,
        CFG_DECAY  = 2'd2,
        CFG_DT     = 2'd3
    } cfg_idx_t;

    localparam logic [31:0] RABI_RESET   = 32'd21810381;
    localparam logic [31:0] DETUNE_RESET = 32'd23991419;
    localparam logic [30:0] DECAY_RESET  = 31'd9227469;
    localparam logic [31:0] DT_RESET     = 32'd4294967;

    // fixed point constants
    localparam logic signed [31:0] Q30_ONE   = 32'sd1073741824;
    localparam logic [31:0]        SEED_LOW  = 32'd916495976;
    localparam logic [31:0]        SEED_HIGH = 32'd648060520;
    localparam logic [35:0]        THREE_Q30 = 36'd3 << 30;
    localparam logic [34:0]        X_LOW     = 35'd1 << 30;
    localparam logic [34:0]        X_MID     = 35'd1 << 31;

    typedef struct packed {
        logic        action;
        logic [31:0] uniform_draw;
    } step_in_t;

    typedef struct packed {
        logic        jumped;
        logic [31:0] amp0_re;
        logic [31:0] amp0_im;
        logic [31:0] amp1_re;
        logic [31:0] amp1_im;
        logic [31:0] expect_x;
        logic [31:0] expect_y;
        logic [31:0] expect_z;
        logic [30:0] population0;
        logic [30:0] population1;
        logic [31:0] jump_total;
    } step_out_t;

    // sequencer steps, one-hot
    localparam int StepW = 50;
    typedef enum logic [StepW-1:0] {
        ST_IDLE  = 50'd1 << 0,
        ST_RST   = 50'd1 << 1,
        ST_PA0   = 50'd1 << 2,
        ST_PA1   = 50'd1 << 3,
        ST_PA2   = 50'd1 << 4,
        ST_G0    = 50'd1 << 5,
        ST_G1    = 50'd1 << 6,
        ST_G2    = 50'd1 << 7,
        ST_PR0   = 50'd1 << 8,
        ST_PR1   = 50'd1 << 9,
        ST_PR2   = 50'd1 << 10,
        ST_BR    = 50'd1 << 11,
        ST_JMP   = 50'd1 << 12,
        ST_E0    = 50'd1 << 13,
        ST_E1    = 50'd1 << 14,
        ST_E2    = 50'd1 << 15,
        ST_E3    = 50'd1 << 16,
        ST_E4    = 50'd1 << 17,
        ST_E5    = 50'd1 << 18,
        ST_E6    = 50'd1 << 19,
        ST_E7    = 50'd1 << 20,
        ST_E8    = 50'd1 << 21,
        ST_E9    = 50'd1 << 22,
        ST_E10   = 50'd1 << 23,
        ST_D0    = 50'd1 << 24,
        ST_D1    = 50'd1 << 25,
        ST_D2    = 50'd1 << 26,
        ST_N0    = 50'd1 << 27,
        ST_N1    = 50'd1 << 28,
        ST_N2    = 50'd1 << 29,
        ST_N3    = 50'd1 << 30,
        ST_N4    = 50'd1 << 31,
        ST_NSH   = 50'd1 << 32,
        ST_NSEED = 50'd1 << 33,
        ST_W0    = 50'd1 << 34,
        ST_W1    = 50'd1 << 35,
        ST_W2    = 50'd1 << 36,
        ST_W3    = 50'd1 << 37,
        ST_SC0   = 50'd1 << 38,
        ST_SC1   = 50'd1 << 39,
        ST_O0    = 50'd1 << 40,
        ST_O1    = 50'd1 << 41,
        ST_O2    = 50'd1 << 42,
        ST_O3    = 50'd1 << 43,
        ST_O4    = 50'd1 << 44,
        ST_O5    = 50'd1 << 45,
        ST_O6    = 50'd1 << 46,
        ST_O7    = 50'd1 << 47,
        ST_O8    = 50'd1 << 48,
        ST_FIN   = 50'd1 << 49
    } step_t;

    typedef struct packed {
        step_t              step;
        logic [AmpIdxW-1:0] idx;
        logic               take;
        logic               load_out;
    } cmd_t;

    typedef struct packed {
        logic jump;
        logic x_zero;
        logic x_low;
        logic x_high;
    } status_t;

    // clamp to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (v < -64'sh0000_0000_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/qjs_if.sv
// qjs_in_if, qjs_out_if: valid/ready channels for step requests and results
// depends on qjs_pkg
interface qjs_in_if;
    import qjs_pkg::*;
    logic     valid;
    logic     ready;
    step_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport mon (input valid, input payload, input ready);
endinterface

interface qjs_out_if;
    import qjs_pkg::*;
    logic      valid;
    logic      ready;
    step_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport mon (input valid, input payload, input ready);
endinterface

### rtl/qjs_datapath.sv
// qjs_datapath: amplitude state, configuration registers, shared multiplier
// and the accumulators driven step by step by qjs_ctrl; depends on qjs_pkg
module qjs_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qjs_pkg::cmd_t            cmd,
    output qjs_pkg::status_t         status,
    input  logic [31:0]              uniform_draw,
    input  logic                     cfg_we,
    input  logic [qjs_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [qjs_pkg::CfgDataW-1:0] cfg_wdata,
    output qjs_pkg::step_out_t       result
);
    import qjs_pkg::*;

    // configuration
    logic signed [31:0] rabi_reg;
    logic signed [31:0] detune_reg;
    logic [30:0]        decay_reg;
    logic [31:0]        dt_reg;

    // architectural state
    logic signed [31:0] amp_reg [NumAmps];
    logic [31:0]        cnt_reg;
    logic               jumped_reg;

    // working registers
    logic signed [65:0] prod_reg;
    logic signed [79:0] acc_reg;
    logic [31:0]        u_reg;
    logic [63:0]        pa_reg;
    logic [34:0]        g_reg;
    logic               jump_reg;
    logic signed [41:0] dv_reg [NumAmps];
    logic [34:0]        x_reg;
    logic signed [4:0]  s_reg;
    logic [31:0]        y_reg;
    logic               tge_reg;
    logic [33:0]        p0_reg;
    logic [33:0]        p1_reg;
    logic signed [35:0] ex_reg;
    logic signed [35:0] ey_reg;
    step_out_t          out_reg;

    logic signed [32:0] ma;
    logic signed [32:0] mb;

    logic signed [31:0] ar, ai, br, bi, amp_sel;
    logic signed [41:0] dv_sel;
    logic signed [32:0] rabi33, detune33, decay33, dt33, y33;

    assign ar       = amp_reg[0];
    assign ai       = amp_reg[1];
    assign br       = amp_reg[2];
    assign bi       = amp_reg[3];
    assign amp_sel  = amp_reg[cmd.idx];
    assign dv_sel   = dv_reg[cmd.idx];
    assign rabi33   = {rabi_reg[31], rabi_reg};
    assign detune33 = {detune_reg[31], detune_reg};
    assign decay33  = {2'b00, decay_reg};
    assign dt33     = {1'b0, dt_reg};
    assign y33      = {1'b0, y_reg};

    // derived values from the product register
    logic signed [79:0] p80, half_sum, half_dif, u_sum, u_dif, neg_sum, neg_dif;
    logic signed [79:0] sum17, sum20, delta, amp_new, damp;
    logic [67:0]        psum;
    logic [42:0]        p_jump;
    logic [35:0]        t_val;
    logic [35:0]        three_minus;
    logic signed [63:0] v64, sv;
    logic [4:0]         neg_s;
    logic [32:0]        sq30;
    logic signed [34:0] xy29;
    logic signed [34:0] ez35;

    assign p80         = {{14{prod_reg[65]}}, prod_reg};
    assign half_sum    = acc_reg + (p80 >>> 1);
    assign half_dif    = acc_reg - (p80 >>> 1);
    assign u_sum       = half_sum >>> 24;
    assign u_dif       = half_dif >>> 24;
    assign neg_sum     = -u_sum;
    assign neg_dif     = -u_dif;
    assign damp        = p80 >>> 25;
    assign sum17       = acc_reg + (p80 <<< 17);
    assign sum20       = acc_reg + (p80 <<< 20);
    assign delta       = sum20 >>> 32;
    assign amp_new     = {{48{amp_sel[31]}}, amp_sel} + delta;
    assign psum        = sum17[67:0];
    assign p_jump      = psum[66:24];
    assign t_val       = prod_reg[65:30];
    assign three_minus = THREE_Q30 - t_val;
    assign v64         = {{28{prod_reg[65]}}, prod_reg[65:30]};
    assign neg_s       = -s_reg;
    assign sv          = s_reg[4] ? (v64 >>> neg_s) : (v64 <<< s_reg[3:0]);
    assign sq30        = prod_reg[62:30];
    assign xy29        = prod_reg[63:29];
    assign ez35        = $signed({1'b0, p0_reg}) - $signed({1'b0, p1_reg});

    // multiplier operand selection
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.step)
            ST_PA0, ST_N0, ST_O0:  begin ma = {ar[31], ar}; mb = {ar[31], ar}; end
            ST_PA1, ST_N1, ST_O1:  begin ma = {ai[31], ai}; mb = {ai[31], ai}; end
            ST_N2, ST_O2:          begin ma = {br[31], br}; mb = {br[31], br}; end
            ST_N3, ST_O3:          begin ma = {bi[31], bi}; mb = {bi[31], bi}; end
            ST_O4:                 begin ma = {ar[31], ar}; mb = {br[31], br}; end
            ST_O5:                 begin ma = {ai[31], ai}; mb = {bi[31], bi}; end
            ST_O6:                 begin ma = {ai[31], ai}; mb = {br[31], br}; end
            ST_O7:                 begin ma = {ar[31], ar}; mb = {bi[31], bi}; end
            ST_G0:                 begin ma = decay33; mb = {16'd0, pa_reg[46:30]}; end
            ST_G1:                 begin ma = decay33; mb = {16'd0, pa_reg[63:47]}; end
            ST_PR0:                begin ma = dt33; mb = {16'd0, g_reg[16:0]}; end
            ST_PR1:                begin ma = dt33; mb = {15'd0, g_reg[34:17]}; end
            ST_E0:                 begin ma = detune33; mb = {ar[31], ar}; end
            ST_E1:                 begin ma = rabi33; mb = {br[31], br}; end
            ST_E2:                 begin ma = detune33; mb = {ai[31], ai}; end
            ST_E3:                 begin ma = rabi33; mb = {bi[31], bi}; end
            ST_E4:                 begin ma = rabi33; mb = {ar[31], ar}; end
            ST_E5:                 begin ma = detune33; mb = {br[31], br}; end
            ST_E6:                 begin ma = rabi33; mb = {ai[31], ai}; end
            ST_E7:                 begin ma = detune33; mb = {bi[31], bi}; end
            ST_E8:                 begin ma = decay33; mb = {ar[31], ar}; end
            ST_E9:                 begin ma = decay33; mb = {ai[31], ai}; end
            ST_D0:                 begin ma = {13'd0, dv_sel[19:0]}; mb = dt33; end
            ST_D1:                 begin ma = {{11{dv_sel[41]}}, dv_sel[41:20]}; mb = dt33; end
            ST_W0:                 begin ma = y33; mb = y33; end
            ST_W1:                 begin ma = {1'b0, x_reg[31:0]}; mb = {1'b0, prod_reg[61:30]}; end
            ST_W2:                 begin ma = y33; mb = {1'b0, three_minus[31:0]}; end
            ST_SC0:                begin ma = {amp_sel[31], amp_sel}; mb = y33; end
            default:               begin ma = '0; mb = '0; end
        endcase
    end

    // shared multiplier, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
    end

    // configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rabi_reg   <= RABI_RESET;
            detune_reg <= DETUNE_RESET;
            decay_reg  <= DECAY_RESET;
            dt_reg     <= DT_RESET;
            amp_reg[0] <= '0;
            amp_reg[1] <= '0;
            amp_reg[2] <= Q30_ONE;
            amp_reg[3] <= '0;
            cnt_reg    <= '0;
            jumped_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RABI:   rabi_reg   <= cfg_wdata;
                    CFG_DETUNE: detune_reg <= cfg_wdata;
                    CFG_DECAY:  decay_reg  <= cfg_wdata[30:0];
                    CFG_DT:     dt_reg     <= cfg_wdata;
                    default:    ;
                endcase
            end
            if (cmd.take)
            begin
                jumped_reg <= 1'b0;
            end
            case (cmd.step)
                ST_RST:
                begin
                    amp_reg[0] <= '0;
                    amp_reg[1] <= '0;
                    amp_reg[2] <= Q30_ONE;
                    amp_reg[3] <= '0;
                    cnt_reg    <= '0;
                    jumped_reg <= 1'b0;
                end
                ST_JMP:
                begin
                    amp_reg[0] <= '0;
                    amp_reg[1] <= '0;
                    amp_reg[2] <= ar;
                    amp_reg[3] <= ai;
                    cnt_reg    <= cnt_reg + 32'd1;
                    jumped_reg <= 1'b1;
                end
                ST_D2:  amp_reg[cmd.idx] <= sat32(amp_new[63:0]);
                ST_SC1: amp_reg[cmd.idx] <= sat32(sv);
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            u_reg <= uniform_draw;
        end
        case (cmd.step)
            ST_PA1: pa_reg <= prod_reg[63:0];
            ST_PA2: pa_reg <= pa_reg + prod_reg[63:0];
            ST_G1, ST_PR1, ST_D1: acc_reg <= p80;
            ST_G2:  g_reg <= sum17[64:30];
            ST_PR2: jump_reg <= (pa_reg != 64'd0) && ({11'd0, u_reg} <= p_jump);
            ST_E1, ST_E3, ST_E5, ST_E7: acc_reg <= p80 >>> 1;
            ST_E2:  dv_reg[1] <= u_sum[41:0];
            ST_E4:  dv_reg[0] <= neg_sum[41:0];
            ST_E6:  dv_reg[3] <= u_dif[41:0];
            ST_E8:  dv_reg[2] <= neg_dif[41:0];
            ST_E9:  dv_reg[0] <= dv_reg[0] - damp[41:0];
            ST_E10: dv_reg[1] <= dv_reg[1] - damp[41:0];
            ST_N1:
            begin
                x_reg <= {2'b00, sq30};
                s_reg <= '0;
            end
            ST_N2, ST_N3, ST_N4: x_reg <= x_reg + {2'b00, sq30};
            ST_NSH:
            begin
                if (x_reg < X_LOW)
                begin
                    x_reg <= x_reg << 2;
                    s_reg <= s_reg + 5'sd1;
                end
                else if (x_reg[34:32] != 3'd0)
                begin
                    x_reg <= x_reg >> 2;
                    s_reg <= s_reg - 5'sd1;
                end
            end
            ST_NSEED: y_reg <= (x_reg < X_MID) ? SEED_LOW : SEED_HIGH;
            ST_W2:  tge_reg <= (t_val >= THREE_Q30);
            ST_W3:  y_reg <= tge_reg ? 32'd0 : prod_reg[62:31];
            ST_O1:  p0_reg <= {1'b0, sq30};
            ST_O2:  p0_reg <= p0_reg + {1'b0, sq30};
            ST_O3:  p1_reg <= {1'b0, sq30};
            ST_O4:  p1_reg <= p1_reg + {1'b0, sq30};
            ST_O5:  ex_reg <= {xy29[34], xy29};
            ST_O6:  ex_reg <= ex_reg + {xy29[34], xy29};
            ST_O7:  ey_reg <= {xy29[34], xy29};
            ST_O8:  ey_reg <= ey_reg - {xy29[34], xy29};
            default: ;
        endcase
        // result register
        if (cmd.load_out)
        begin
            out_reg.jumped      <= jumped_reg;
            out_reg.amp0_re     <= ar;
            out_reg.amp0_im     <= ai;
            out_reg.amp1_re     <= br;
            out_reg.amp1_im     <= bi;
            out_reg.expect_x    <= sat32({{28{ex_reg[35]}}, ex_reg});
            out_reg.expect_y    <= sat32({{28{ey_reg[35]}}, ey_reg});
            out_reg.expect_z    <= sat32({{29{ez35[34]}}, ez35});
            out_reg.population0 <= (p0_reg > 34'(Q30_ONE)) ? 31'(Q30_ONE) : p0_reg[30:0];
            out_reg.population1 <= (p1_reg > 34'(Q30_ONE)) ? 31'(Q30_ONE) : p1_reg[30:0];
            out_reg.jump_total  <= cnt_reg;
        end
    end

    assign status.jump   = jump_reg;
    assign status.x_zero = (x_reg == 35'd0);
    assign status.x_low  = (x_reg < X_LOW);
    assign status.x_high = (x_reg[34:32] != 3'd0);
    assign result        = out_reg;

endmodule

### rtl/qjs_ctrl.sv
// qjs_ctrl: step sequencer for the quantum jump unit, owns the handshakes
// and loop counters; depends on qjs_pkg
module qjs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_action,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  qjs_pkg::status_t status,
    output qjs_pkg::cmd_t    cmd
);
    import qjs_pkg::*;

    step_t              state_reg, state_next;
    logic [AmpIdxW-1:0] idx_reg, idx_next;
    logic [IterW-1:0]   iter_reg, iter_next;
    logic               out_valid_reg, out_valid_next;
    logic               take;
    logic               load;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;
    assign load     = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // next step
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = in_action ? ST_RST : ST_PA0;
                end
            end
            ST_RST:  state_next = ST_O0;
            ST_PA0:  state_next = ST_PA1;
            ST_PA1:  state_next = ST_PA2;
            ST_PA2:  state_next = ST_G0;
            ST_G0:   state_next = ST_G1;
            ST_G1:   state_next = ST_G2;
            ST_G2:   state_next = ST_PR0;
            ST_PR0:  state_next = ST_PR1;
            ST_PR1:  state_next = ST_PR2;
            ST_PR2:  state_next = ST_BR;
            ST_BR:   state_next = status.jump ? ST_JMP : ST_E0;
            ST_JMP:  state_next = ST_N0;
            ST_E0:   state_next = ST_E1;
            ST_E1:   state_next = ST_E2;
            ST_E2:   state_next = ST_E3;
            ST_E3:   state_next = ST_E4;
            ST_E4:   state_next = ST_E5;
            ST_E5:   state_next = ST_E6;
            ST_E6:   state_next = ST_E7;
            ST_E7:   state_next = ST_E8;
            ST_E8:   state_next = ST_E9;
            ST_E9:   state_next = ST_E10;
            ST_E10:
            begin
                state_next = ST_D0;
                idx_next   = '0;
            end
            ST_D0:   state_next = ST_D1;
            ST_D1:   state_next = ST_D2;
            ST_D2:
            begin
                if (idx_reg == AmpIdxW'(NumAmps - 1))
                begin
                    state_next = ST_N0;
                end
                else
                begin
                    state_next = ST_D0;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            ST_N0:   state_next = ST_N1;
            ST_N1:   state_next = ST_N2;
            ST_N2:   state_next = ST_N3;
            ST_N3:   state_next = ST_N4;
            ST_N4:   state_next = ST_NSH;
            ST_NSH:
            begin
                if (status.x_zero)
                begin
                    state_next = ST_O0;
                end
                else if (!status.x_low && !status.x_high)
                begin
                    state_next = ST_NSEED;
                end
            end
            ST_NSEED:
            begin
                state_next = ST_W0;
                iter_next  = '0;
            end
            ST_W0:   state_next = ST_W1;
            ST_W1:   state_next = ST_W2;
            ST_W2:   state_next = ST_W3;
            ST_W3:
            begin
                if (iter_reg == IterW'(NORM_ITERATIONS - 1))
                begin
                    state_next = ST_SC0;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = ST_W0;
                    iter_next  = iter_reg + 1'b1;
                end
            end
            ST_SC0:  state_next = ST_SC1;
            ST_SC1:
            begin
                if (idx_reg == AmpIdxW'(NumAmps - 1))
                begin
                    state_next = ST_O0;
                end
                else
                begin
                    state_next = ST_SC0;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            ST_O0:   state_next = ST_O1;
            ST_O1:   state_next = ST_O2;
            ST_O2:   state_next = ST_O3;
            ST_O3:   state_next = ST_O4;
            ST_O4:   state_next = ST_O5;
            ST_O5:   state_next = ST_O6;
            ST_O6:   state_next = ST_O7;
            ST_O7:   state_next = ST_O8;
            ST_O8:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cmd.step     = state_reg;
    assign cmd.idx      = idx_reg;
    assign cmd.take     = take;
    assign cmd.load_out = load;

endmodule

### rtl/two_level_quantum_jump_step_unit.sv
// two_level_quantum_jump_step_unit: top level, joins the sequencer and
// the datapath to the channels; depends on qjs_pkg, qjs_if, qjs_ctrl, qjs_datapath
//
// step_in carries one item per time step: action 0 advances the trajectory
// using uniform_draw, action 1 restarts in state [0,1] and clears the jump count.
// step_out returns exactly one item per accepted input: amplitudes,
// expectations, populations, jump flag and jump count.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes omega, delta,
// gamma and dt; write only while no item is in flight.
// All multiplications run through one shared registered 33x33 multiplier
// stepped by the sequencer. A restart goes straight to the output steps. A
// jump step computes the jump probability, jumps, normalizes and computes the
// outputs; an Euler step does the same with the Euler update in place of the
// jump. The normalize shift step repeats until x is in range; each Newton
// iteration runs W0 to W3, the Euler update E0 to E10 and D0 to D2 per amp.
// One item is worked on at a time; a new item is accepted while a finished
// result still waits in the output register.
// Reset puts the state at [0,1], clears the jump count and loads the default
// coefficients. If the receiver stalls, the result holds and the next item
// stops at its last step until the output register frees.
module two_level_quantum_jump_step_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    qjs_in_if.sink                        step_in,
    qjs_out_if.source                     step_out,
    input  logic                          cfg_we,
    input  logic [qjs_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [qjs_pkg::CfgDataW-1:0]  cfg_wdata
);
    import qjs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // step sequencer
    qjs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step_in.valid),
        .in_action (step_in.payload.action),
        .in_ready  (step_in.ready),
        .out_valid (step_out.valid),
        .out_ready (step_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and state
    qjs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .uniform_draw (step_in.payload.uniform_draw),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .result       (step_out.payload)
    );

endmodule

### rtl/qjs_checker.sv
// qjs_checker: port level checks on the quantum jump unit results,
// bound to the top level; depends on qjs_pkg
module qjs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input qjs_pkg::step_out_t out_payload
);
    import qjs_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result changed or dropped while stalled");

    // after a jump the first level is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.jumped |->
            out_payload.amp0_re == 32'd0 && out_payload.amp0_im == 32'd0)
        else $error("jump left a nonzero first amplitude");

    // after a jump there is no coherence and no first level population
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.jumped |->
            out_payload.population0 == 31'd0 && out_payload.expect_x == 32'd0 &&
            out_payload.expect_y == 32'd0)
        else $error("jump result shows first level population or coherence");

    // populations stay clamped to one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            out_payload.population0 <= 31'(Q30_ONE) &&
            out_payload.population1 <= 31'(Q30_ONE))
        else $error("population above one");

endmodule

bind two_level_quantum_jump_step_unit qjs_checker u_qjs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (step_out.valid),
    .out_ready   (step_out.ready),
    .out_payload (step_out.payload)
);
